// File: sv/cau_pkg.sv
// cau_pkg: shared types and codes for the complex arithmetic unit.
// No dependencies; imported by every module of the unit.
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_RECIP = 3'd4,
    OP_MAG   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_DIRECT  = 3'd0,
    K_DIV     = 3'd1,
    K_DIVZERO = 3'd2,
    K_SQRT    = 3'd3,
    K_ZERO    = 3'd4
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  sat;
    logic  neg_re;
    logic  neg_im;
    logic  ovf_re;
    logic  ovf_im;
  } ctl_t;

endpackage

// File: sv/cau_front.sv
// cau_front: four front stages: operand register, products, sums, divider setup.
// Depends on cau_pkg.
module cau_front
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [2:0]                   in_op,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output ctl_t                         ctl,
  output logic [DATA_WIDTH-1:0]        dir_re,
  output logic [DATA_WIDTH-1:0]        dir_im,
  output logic [2*DATA_WIDTH-1:0]      den,
  output logic [2*DATA_WIDTH-1:0]      rem_re,
  output logic [2*DATA_WIDTH-1:0]      rem_im,
  output logic [DATA_WIDTH-1:0]        bits_re,
  output logic [DATA_WIDTH-1:0]        bits_im
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int DW  = 2 * W;
  localparam int NRW = (2 * W + 1 > W + F + 1) ? 2 * W + 1 : W + F + 1;
  localparam int NW  = NRW - 1;
  localparam int DVW = NW + F;
  localparam int CW  = ((DVW > 3 * W) ? DVW : 3 * W) + 1;
  localparam logic signed [NRW-1:0] MAXV = {{(NRW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NRW-1:0] MINV = {{(NRW-W+1){1'b1}}, {(W-1){1'b0}}};

  // stage 1
  logic                 v1;
  logic [2:0]           op1;
  logic signed [W-1:0]  ar1, ai1, br1, bi1;
  // stage 2
  logic                 v2;
  logic [2:0]           op2;
  logic signed [W-1:0]  ar2, ai2, br2, bi2;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, q0, q1;
  logic signed [W-1:0]  sa, sb;
  // stage 3
  logic                 v3;
  logic [2:0]           op3;
  logic signed [NRW-1:0] nre3, nim3, nre_n, nim_n;
  logic [DW-1:0]        den3;
  logic [DW:0]          den_sum;
  logic signed [NRW-1:0] x_rr, x_ii, x_ir, x_ri;
  // stage 4 setup
  ctl_t                 ctl_n;
  logic [W-1:0]         dre_n, dim_n;
  logic signed [NRW-1:0] nx [2];
  logic [DW-1:0]        rem_n [2];
  logic [W-1:0]         bits_n [2];
  logic                 ovf_n [2];
  logic signed [NRW-1:0] shr_re, shr_im;
  logic [W:0]           cl_re, cl_im;
  logic [NW-1:0]        mag;
  logic [DVW-1:0]       dvd;

  function automatic logic [W:0] clamp(input logic signed [NRW-1:0] x);
    logic [W:0] r;
    if (x > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (x < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      op1 <= in_op;
      ar1 <= in_a_re;
      ai1 <= in_a_im;
      br1 <= in_b_re;
      bi1 <= in_b_im;
    end
  end

  assign sa = (op1 == OP_DIV) ? br1 : ar1;
  assign sb = (op1 == OP_DIV) ? bi1 : ai1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2  <= op1;
      ar2  <= ar1;
      ai2  <= ai1;
      br2  <= br1;
      bi2  <= bi1;
      p_rr <= ar1 * br1;
      p_ii <= ai1 * bi1;
      p_ir <= ai1 * br1;
      p_ri <= ar1 * bi1;
      q0   <= sa * sa;
      q1   <= sb * sb;
    end
  end

  always_comb begin
    x_rr    = NRW'(p_rr);
    x_ii    = NRW'(p_ii);
    x_ir    = NRW'(p_ir);
    x_ri    = NRW'(p_ri);
    den_sum = {1'b0, q0} + {1'b0, q1};
    case (op2)
      OP_ADD: begin
        nre_n = NRW'(ar2) + NRW'(br2);
        nim_n = NRW'(ai2) + NRW'(bi2);
      end
      OP_SUB: begin
        nre_n = NRW'(ar2) - NRW'(br2);
        nim_n = NRW'(ai2) - NRW'(bi2);
      end
      OP_MUL: begin
        nre_n = x_rr - x_ii;
        nim_n = x_ir + x_ri;
      end
      OP_DIV: begin
        nre_n = x_rr + x_ii;
        nim_n = x_ir - x_ri;
      end
      OP_RECIP: begin
        nre_n = NRW'(ar2) <<< F;
        nim_n = -(NRW'(ai2) <<< F);
      end
      default: begin
        nre_n = '0;
        nim_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3  <= op2;
      nre3 <= nre_n;
      nim3 <= nim_n;
      den3 <= den_sum[DW-1:0];
    end
  end

  // divider setup: magnitude, overflow check, first partial remainder
  always_comb begin
    nx[0] = nre3;
    nx[1] = nim3;
    mag   = '0;
    dvd   = '0;
    for (int k = 0; k < 2; k++) begin
      mag       = nx[k][NRW-1] ? NW'(-nx[k]) : NW'(nx[k]);
      dvd       = {mag, {F{1'b0}}};
      ovf_n[k]  = CW'(dvd) >= (CW'(den3) << W);
      rem_n[k]  = DW'(dvd >> W);
      bits_n[k] = dvd[W-1:0];
    end
    shr_re = (op3 == OP_MUL) ? (nre3 >>> F) : nre3;
    shr_im = (op3 == OP_MUL) ? (nim3 >>> F) : nim3;
    cl_re  = clamp(shr_re);
    cl_im  = clamp(shr_im);
    dre_n  = cl_re[W-1:0];
    dim_n  = cl_im[W-1:0];
    ctl_n.valid  = v3;
    ctl_n.sat    = cl_re[W] | cl_im[W];
    ctl_n.neg_re = nre3[NRW-1];
    ctl_n.neg_im = nim3[NRW-1];
    ctl_n.ovf_re = ovf_n[0];
    ctl_n.ovf_im = ovf_n[1];
    case (op3)
      OP_ADD, OP_SUB, OP_MUL: ctl_n.kind = K_DIRECT;
      OP_DIV, OP_RECIP:       ctl_n.kind = (den3 == '0) ? K_DIVZERO : K_DIV;
      OP_MAG:                 ctl_n.kind = K_SQRT;
      default:                ctl_n.kind = K_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_n;
    end
    if (en) begin
      dir_re  <= dre_n;
      dir_im  <= dim_n;
      den     <= den3;
      rem_re  <= rem_n[0];
      rem_im  <= rem_n[1];
      bits_re <= bits_n[0];
      bits_im <= bits_n[1];
    end
  end

endmodule

// File: sv/cau_stage.sv
// cau_stage: one pipeline step of the two restoring dividers and the square root.
// Depends on cau_pkg.
module cau_stage
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  ctl_t                    ctl_in,
  input  logic [DATA_WIDTH-1:0]   dir_re_in,
  input  logic [DATA_WIDTH-1:0]   dir_im_in,
  input  logic [2*DATA_WIDTH-1:0] den_in,
  input  logic [2*DATA_WIDTH-1:0] rem_re_in,
  input  logic [2*DATA_WIDTH-1:0] rem_im_in,
  input  logic [DATA_WIDTH-1:0]   bits_re_in,
  input  logic [DATA_WIDTH-1:0]   bits_im_in,
  input  logic [DATA_WIDTH-1:0]   q_re_in,
  input  logic [DATA_WIDTH-1:0]   q_im_in,
  input  logic [2*DATA_WIDTH-1:0] sq_in,
  input  logic [DATA_WIDTH+1:0]   srem_in,
  input  logic [DATA_WIDTH-1:0]   sres_in,
  output ctl_t                    ctl_out,
  output logic [DATA_WIDTH-1:0]   dir_re_out,
  output logic [DATA_WIDTH-1:0]   dir_im_out,
  output logic [2*DATA_WIDTH-1:0] den_out,
  output logic [2*DATA_WIDTH-1:0] rem_re_out,
  output logic [2*DATA_WIDTH-1:0] rem_im_out,
  output logic [DATA_WIDTH-1:0]   bits_re_out,
  output logic [DATA_WIDTH-1:0]   bits_im_out,
  output logic [DATA_WIDTH-1:0]   q_re_out,
  output logic [DATA_WIDTH-1:0]   q_im_out,
  output logic [2*DATA_WIDTH-1:0] sq_out,
  output logic [DATA_WIDTH+1:0]   srem_out,
  output logic [DATA_WIDTH-1:0]   sres_out
);

  localparam int W  = DATA_WIDTH;
  localparam int DW = 2 * W;

  logic [DW:0]   r2_re, r2_im;
  logic [DW-1:0] rn_re, rn_im;
  logic          qb_re, qb_im;
  logic [W+1:0]  s2, trial, sn;
  logic          sb;

  always_comb begin
    r2_re = {rem_re_in, bits_re_in[W-1]};
    r2_im = {rem_im_in, bits_im_in[W-1]};
    qb_re = r2_re >= {1'b0, den_in};
    qb_im = r2_im >= {1'b0, den_in};
    rn_re = qb_re ? DW'(r2_re - {1'b0, den_in}) : r2_re[DW-1:0];
    rn_im = qb_im ? DW'(r2_im - {1'b0, den_in}) : r2_im[DW-1:0];
    s2    = {srem_in[W-1:0], sq_in[DW-1 -: 2]};
    trial = {sres_in, 2'b01};
    sb    = s2 >= trial;
    sn    = sb ? (s2 - trial) : s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      dir_re_out  <= dir_re_in;
      dir_im_out  <= dir_im_in;
      den_out     <= den_in;
      rem_re_out  <= rn_re;
      rem_im_out  <= rn_im;
      bits_re_out <= {bits_re_in[W-2:0], 1'b0};
      bits_im_out <= {bits_im_in[W-2:0], 1'b0};
      q_re_out    <= {q_re_in[W-2:0], qb_re};
      q_im_out    <= {q_im_in[W-2:0], qb_im};
      sq_out      <= {sq_in[DW-3:0], 2'b00};
      srem_out    <= sn;
      sres_out    <= {sres_in[W-2:0], sb};
    end
  end

endmodule

// File: sv/complex_arith_unit.sv
// complex_arith_unit: top level: input skid, front stages, divider/root stages, output.
// Depends on cau_pkg, cau_front and cau_stage.
//
// Complex add, subtract, multiply, divide, reciprocal and magnitude in signed fixed point
// (Q16.16 by default). One beat is taken every cycle while the pipeline is not stalled; the
// result leaves through an output register after the DATA_WIDTH-step divider and square-root
// pipeline that follows four front stages. Every op travels the full depth, so results
// leave in input order. Backpressure on m_tready freezes the whole pipeline; a one-beat
// skid buffer keeps s_tready a register output.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_DW     = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]        s_tuser,   // op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // res_re, res_im
  output logic [1:0]        m_tuser    // status
);

  localparam int W  = DATA_WIDTH;
  localparam int DW = 2 * W;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  logic              en;
  logic              skid_valid;
  logic [IN_DW-1:0]  skid_data;
  logic [2:0]        skid_user;
  logic              src_valid;
  logic [IN_DW-1:0]  src_data;
  logic [2:0]        src_user;

  ctl_t          st_ctl  [W+1];
  logic [W-1:0]  st_dre  [W+1];
  logic [W-1:0]  st_dim  [W+1];
  logic [DW-1:0] st_den  [W+1];
  logic [DW-1:0] st_rre  [W+1];
  logic [DW-1:0] st_rim  [W+1];
  logic [W-1:0]  st_bre  [W+1];
  logic [W-1:0]  st_bim  [W+1];
  logic [W-1:0]  st_qre  [W+1];
  logic [W-1:0]  st_qim  [W+1];
  logic [DW-1:0] st_sq   [W+1];
  logic [W+1:0]  st_srem [W+1];
  logic [W-1:0]  st_sres [W+1];

  ctl_t          fin;
  logic [W:0]    pr_re, pr_im;
  logic [W-1:0]  res_re_next, res_im_next;
  logic [1:0]    status_next;
  logic [W-1:0]  res_re, res_im;

  function automatic logic [W:0] div_part(input logic [W-1:0] q, input logic neg,
                                          input logic ovf);
    logic [W:0] r;
    if (ovf) begin
      r = {1'b1, neg ? MINW : MAXW};
    end else if (!neg) begin
      r = (q > MAXW) ? {1'b1, MAXW} : {1'b0, q};
    end else begin
      r = (q > MINW) ? {1'b1, MINW} : {1'b0, W'(-q)};
    end
    return r;
  endfunction

  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
    if (!en && !skid_valid) begin
      skid_data <= s_tdata;
      skid_user <= s_tuser;
    end
  end

  assign src_valid = skid_valid || s_tvalid;
  assign src_data  = skid_valid ? skid_data : s_tdata;
  assign src_user  = skid_valid ? skid_user : s_tuser;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(src_valid),
    .in_op   (src_user),
    .in_a_re (src_data[W-1:0]),
    .in_a_im (src_data[2*W-1:W]),
    .in_b_re (src_data[3*W-1:2*W]),
    .in_b_im (src_data[4*W-1:3*W]),
    .ctl     (st_ctl[0]),
    .dir_re  (st_dre[0]),
    .dir_im  (st_dim[0]),
    .den     (st_den[0]),
    .rem_re  (st_rre[0]),
    .rem_im  (st_rim[0]),
    .bits_re (st_bre[0]),
    .bits_im (st_bim[0])
  );

  assign st_qre[0]  = '0;
  assign st_qim[0]  = '0;
  assign st_sq[0]   = st_den[0];
  assign st_srem[0] = '0;
  assign st_sres[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_stage
    cau_stage #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .ctl_in     (st_ctl[i]),
      .dir_re_in  (st_dre[i]),
      .dir_im_in  (st_dim[i]),
      .den_in     (st_den[i]),
      .rem_re_in  (st_rre[i]),
      .rem_im_in  (st_rim[i]),
      .bits_re_in (st_bre[i]),
      .bits_im_in (st_bim[i]),
      .q_re_in    (st_qre[i]),
      .q_im_in    (st_qim[i]),
      .sq_in      (st_sq[i]),
      .srem_in    (st_srem[i]),
      .sres_in    (st_sres[i]),
      .ctl_out    (st_ctl[i+1]),
      .dir_re_out (st_dre[i+1]),
      .dir_im_out (st_dim[i+1]),
      .den_out    (st_den[i+1]),
      .rem_re_out (st_rre[i+1]),
      .rem_im_out (st_rim[i+1]),
      .bits_re_out(st_bre[i+1]),
      .bits_im_out(st_bim[i+1]),
      .q_re_out   (st_qre[i+1]),
      .q_im_out   (st_qim[i+1]),
      .sq_out     (st_sq[i+1]),
      .srem_out   (st_srem[i+1]),
      .sres_out   (st_sres[i+1])
    );
  end

  always_comb begin
    fin   = st_ctl[W];
    pr_re = div_part(st_qre[W], fin.neg_re, fin.ovf_re);
    pr_im = div_part(st_qim[W], fin.neg_im, fin.ovf_im);
    case (fin.kind)
      K_DIRECT: begin
        res_re_next = st_dre[W];
        res_im_next = st_dim[W];
        status_next = fin.sat ? ST_SAT : ST_OK;
      end
      K_DIV: begin
        res_re_next = pr_re[W-1:0];
        res_im_next = pr_im[W-1:0];
        status_next = (pr_re[W] || pr_im[W]) ? ST_SAT : ST_OK;
      end
      K_DIVZERO: begin
        res_re_next = '0;
        res_im_next = '0;
        status_next = ST_DIV0;
      end
      K_SQRT: begin
        res_re_next = (st_sres[W] > MAXW) ? MAXW : st_sres[W];
        res_im_next = '0;
        status_next = (st_sres[W] > MAXW) ? ST_SAT : ST_OK;
      end
      default: begin
        res_re_next = '0;
        res_im_next = '0;
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fin.valid;
    end
    if (en) begin
      res_re  <= res_re_next;
      res_im  <= res_im_next;
      m_tuser <= status_next;
    end
  end

  assign m_tdata = OUT_DW'({res_im, res_re});

endmodule

// File: sv/cau_checker.sv
// cau_checker: port-level checks on the result stream of complex_arith_unit.
// Depends on cau_pkg; bound to the top level at the end of this file.
module cau_checker
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int OUT_DW    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_DW-1:0] m_tdata,
  input logic [1:0]        m_tuser
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_DIV0 |-> m_tdata[2*W-1:0] == '0)
    else $error("divide-by-zero beat carries nonzero result");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_SAT |->
      m_tdata[W-1:0] == MAXW || m_tdata[W-1:0] == MINW ||
      m_tdata[2*W-1:W] == MAXW || m_tdata[2*W-1:W] == MINW)
    else $error("saturated beat has no clamped part");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

// File: tb/cau_checker.sv
// cau_scoreboard: watches both stream channels of complex_arith_unit, predicts each result
// from the accepted input beat and compares it field by field. Depends on cau_pkg.
module cau_scoreboard
  import cau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t            st;
  } cplx_res_t;

  cplx_res_t result_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, inout bit hit);
    if (v > 128'sd2147483647) begin
      hit = 1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      hit = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // (num << FB) / den, truncated toward zero
  function automatic logic signed [127:0] qdiv(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
    logic signed [127:0] sh;
    sh = num <<< FB;
    return sh / den;
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] bitv;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      bitv = r | (128'd1 << i);
      if (bitv * bitv <= s) r = bitv;
    end
    return r;
  endfunction

  function automatic cplx_res_t complex_result(input logic [2:0] op,
                                               input logic [127:0] d);
    logic signed [127:0] ar, ai, br, bi, den, nre, nim;
    cplx_res_t r;
    bit hit;
    ar = $signed(d[31:0]);
    ai = $signed(d[63:32]);
    br = $signed(d[95:64]);
    bi = $signed(d[127:96]);
    hit = 0;
    r.re = 0;
    r.im = 0;
    r.st = ST_OK;
    case (op)
      OP_ADD: begin
        r.re = clamp32(ar + br, hit);
        r.im = clamp32(ai + bi, hit);
      end
      OP_SUB: begin
        r.re = clamp32(ar - br, hit);
        r.im = clamp32(ai - bi, hit);
      end
      OP_MUL: begin
        r.re = clamp32((ar * br - ai * bi) >>> FB, hit);
        r.im = clamp32((ai * br + ar * bi) >>> FB, hit);
      end
      OP_DIV, OP_RECIP: begin
        if (op == OP_DIV) begin
          den = br * br + bi * bi;
          nre = ar * br + ai * bi;
          nim = ai * br - ar * bi;
        end else begin
          den = ar * ar + ai * ai;
          nre = ar <<< FB;
          nim = -(ai <<< FB);
        end
        if (den == 0) r.st = ST_DIV0;
        else begin
          r.re = clamp32(qdiv(nre, den), hit);
          r.im = clamp32(qdiv(nim, den), hit);
        end
      end
      OP_MAG: r.re = clamp32($signed(int_sqrt(ar * ar + ai * ai)), hit);
      default: ;
    endcase
    if (r.st == ST_OK && hit) r.st = ST_SAT;
    return r;
  endfunction

  initial begin
    errors = 0;
    n_results = 0;
  end

  assign pending = result_q.size();

  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) result_q.push_back(complex_result(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        n_results++;
        if (result_q.size() == 0) begin
          errors++;
          $error("unexpected result beat");
        end else begin
          e = result_q.pop_front();
          if (m_tdata[31:0] !== e.re) begin
            errors++;
            $error("res_re: expected %h, got %h", e.re, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== e.im) begin
            errors++;
            $error("res_im: expected %h, got %h", e.im, m_tdata[63:32]);
          end
          if (m_tuser !== e.st) begin
            errors++;
            $error("status: expected %0d, got %0d", e.st, m_tuser);
          end
        end
      end
    end
  end
endmodule

// File: tb/tb_complex_arith_unit.sv
// tb_complex_arith_unit: drives directed and random complex ops through the unit with
// varying idle and stall patterns. Depends on cau_pkg, complex_arith_unit, cau_scoreboard.
module tb_complex_arith_unit;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;
  int errors, pending, n_results;
  int src_idle = 0, snk_stall = 0;
  int n_sent = 0;

  always #10 clk = ~clk;

  complex_arith_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  cau_scoreboard chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .errors, .pending, .n_results
  );

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= snk_stall);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(131072) - 65536;
      4: return $urandom_range(16777216) - 8388608;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {bi, br, ai, ar};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic run_random(input int n, input int idle, input int stall);
    logic [2:0] op;
    src_idle = idle;
    snk_stall = stall;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      if ($urandom_range(15) == 0)
        send_op(op, rand_word(), rand_word(), 32'h0, 32'h0);
      else if ($urandom_range(15) == 0)
        send_op(op, 32'h0, 32'h0, rand_word(), rand_word());
      else
        send_op(op, rand_word(), rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int op = OP_ADD; op <= OP_MAG; op++) begin
      send_op(3'(op), 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_op(3'(op), 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
    end
    send_op(OP_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
    send_op(OP_RECIP, 32'h0, 32'h0, 32'h00010000, 32'h0);
    send_op(OP_RECIP, 32'h00000001, 32'h0, 32'h0, 32'h0);
    send_op(OP_MUL, 32'hffffffff, 32'h0, 32'h00000001, 32'h0);
    send_op(3'd6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(3'd7, 32'h12345678, 32'h0, 32'h0, 32'h0);
    run_random(400, 0, 0);
    run_random(400, 62, 0);
    run_random(400, 0, 62);
    run_random(300, 31, 31);
    s_tvalid <= 0;
    src_idle = 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Covered %0d input beats, %0d result beats, all ops incl. unused codes,",
             n_sent, n_results);
    $display("zero divisors, saturation and mixed source/sink throttling.");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
